// ----- hw/rtl/ibt_pkg.sv -----
package ibt_pkg;

    // Width of each time field on the input stream.
    localparam int FIELD_BITS = 32;

    // Output beat width: accepted flag plus status, padded to a byte.
    localparam int OUT_BITS = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED = 2'd0,
        STATUS_OVERLAP  = 2'd1,
        STATUS_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        logic in_ready;
        logic scan;
        logic commit;
    } t_ctrl;

endpackage

// ----- hw/rtl/ibt_mem.sv -----
module ibt_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ibt_match.sv -----
module ibt_match #(
    parameter int TIME_BITS = 32
) (
    input  logic [TIME_BITS-1:0] i_req_start,
    input  logic [TIME_BITS-1:0] i_req_end,
    input  logic [TIME_BITS-1:0] i_bk_start,
    input  logic [TIME_BITS-1:0] i_bk_end,
    output logic                 o_hit
);

    // Keys are offset binary, so unsigned compares give signed time order.
    logic start_in;
    logic end_in;
    logic covers;

    always_comb begin
        start_in = (i_req_start >= i_bk_start) && (i_req_start <= i_bk_end);
        end_in   = (i_req_end >= i_bk_start) && (i_req_end <= i_bk_end);
        covers   = (i_req_start <= i_bk_start) && (i_req_end >= i_bk_end);
        o_hit    = start_in || end_in || covers;
    end

endmodule

// ----- hw/rtl/interval_booking_table_unit.sv -----
// Interval booking table. Each input beat carries a closed interval
// [start_time, end_time] of signed times; the unit compares it against every
// stored booking and answers with one output beat: accepted (status 0),
// overlap (status 1, the request starts inside, ends inside or covers a
// booking) or table full (status 2, no overlap but MAX_BOOKINGS entries are
// held). Accepted intervals are appended to the table; overlap takes
// precedence over full, and reversed intervals are checked as given. Times
// are the low TIME_BITS bits of each field, sign-extended from bit
// TIME_BITS-1 (zero above bit 31 when TIME_BITS exceeds 32). Bookings live
// in one synchronous memory with a registered read port, scanned one entry
// per cycle, and the scan stops early at the first overlapping entry. One
// request is worked on at a time; the finished result sits in an output
// register, so the next request is taken while that beat waits. After
// reset the table is empty and no clearing pass is needed.
module interval_booking_table_unit #(
    parameter int MAX_BOOKINGS = 64,
    parameter int TIME_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [31:0] start_time, [63:32] end_time
    input  logic [63:0] i_s_tdata,
    // Result stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] accepted, [2:1] status, [7:3] zero
    output logic [7:0]  o_m_tdata
);

    import ibt_pkg::*;

    // Count holds 0..MAX_BOOKINGS; address indexes 0..MAX_BOOKINGS-1.
    localparam int CW = $clog2(MAX_BOOKINGS + 1);
    localparam int AW = (MAX_BOOKINGS > 1) ? $clog2(MAX_BOOKINGS) : 1;
    localparam int DW = 2 * TIME_BITS;

    t_state r_state;
    t_state n_state;
    t_ctrl  ctrl;

    logic [TIME_BITS-1:0] r_req_s;
    logic [TIME_BITS-1:0] r_req_e;
    logic [CW-1:0]        r_idx;
    logic                 r_pend;
    logic                 r_hit;
    logic [CW-1:0]        r_count;
    logic                 r_out_valid;
    logic                 r_out_acc;
    t_status              r_out_status;

    logic [FIELD_BITS+TIME_BITS-1:0] ext_s;
    logic [FIELD_BITS+TIME_BITS-1:0] ext_e;
    logic [TIME_BITS-1:0]            key_s;
    logic [TIME_BITS-1:0]            key_e;

    logic [DW-1:0] rd_data;
    logic          mem_we;
    logic          hit_now;
    logic          match_hit;
    logic          issue;
    logic          scan_done;
    logic          out_free;
    logic          table_full;
    t_status       fin_status;

    // Take the low TIME_BITS of each field (zero above the field) and flip
    // the sign bit to get an offset-binary key.
    always_comb begin
        ext_s = {{TIME_BITS{1'b0}}, i_s_tdata[FIELD_BITS-1:0]};
        ext_e = {{TIME_BITS{1'b0}}, i_s_tdata[2*FIELD_BITS-1:FIELD_BITS]};
        key_s = ext_s[TIME_BITS-1:0] ^ {1'b1, {(TIME_BITS-1){1'b0}}};
        key_e = ext_e[TIME_BITS-1:0] ^ {1'b1, {(TIME_BITS-1){1'b0}}};
    end

    // Bookings are stored as {start key, end key}. Writes happen only at the
    // end of a request and reads only during the next scan, so the same entry
    // is never read and written in one cycle.
    ibt_mem #(
        .DEPTH (MAX_BOOKINGS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_req_s, r_req_e}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    ibt_match #(
        .TIME_BITS (TIME_BITS)
    ) u_match (
        .i_req_start (r_req_s),
        .i_req_end   (r_req_e),
        .i_bk_start  (rd_data[DW-1:TIME_BITS]),
        .i_bk_end    (rd_data[TIME_BITS-1:0]),
        .o_hit       (match_hit)
    );

    // Scan control: issue one read per cycle while entries remain; the data
    // returned for the previous issue is compared in the same cycle.
    always_comb begin
        issue      = (r_idx != r_count);
        hit_now    = r_pend && match_hit;
        scan_done  = hit_now || (!issue && !r_pend);
        out_free   = !r_out_valid || i_m_tready;
        table_full = (r_count == CW'(MAX_BOOKINGS));
        if (r_hit) begin
            fin_status = STATUS_OVERLAP;
        end else if (table_full) begin
            fin_status = STATUS_FULL;
        end else begin
            fin_status = STATUS_ACCEPTED;
        end
        mem_we = ctrl.commit && (fin_status == STATUS_ACCEPTED);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        ctrl = '0;
        case (r_state)
            ST_IDLE:   ctrl.in_ready = 1'b1;
            ST_SCAN:   ctrl.scan     = 1'b1;
            ST_FINISH: ctrl.commit   = out_free;
            default:   ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Latch the request and restart the scan at entry zero.
            if (ctrl.in_ready && i_s_tvalid) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
                r_hit  <= 1'b0;
            end

            // Advance the read pointer; record the first overlapping entry.
            if (ctrl.scan) begin
                r_pend <= issue && !hit_now;
                if (issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (hit_now) begin
                    r_hit <= 1'b1;
                end
            end

            // Append on accept; hand the result to the output register.
            if (mem_we) begin
                r_count <= r_count + CW'(1);
            end
            if (ctrl.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (ctrl.in_ready && i_s_tvalid) begin
            r_req_s <= key_s;
            r_req_e <= key_e;
        end
        if (ctrl.commit) begin
            r_out_status <= fin_status;
            r_out_acc    <= (fin_status == STATUS_ACCEPTED);
        end
    end

    assign o_s_tready = ctrl.in_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_BITS-3){1'b0}}, r_out_status, r_out_acc};

endmodule

// ----- tb/tb.sv -----
module tb;
    import ibt_pkg::*;

    localparam int SLOTS           = 64;      // table capacity of the default build
    localparam int T_MIN           = 32'sh8000_0000;
    localparam int T_MAX           = 32'sh7FFF_FFFF;
    localparam int ITEMS_PER_PHASE = 279;
    localparam int FILL_ITEMS      = 120;     // tame requests first so the table fills up
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 80;      // allows for a worst-case scan over all MAX_BOOKINGS entries
    localparam int STALL_LIMIT     = 5000;

    typedef struct {
        int open_at;
        int close_at;
    } t_interval;

    typedef struct {
        logic    accepted;
        t_status status;
    } t_verdict;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata  = '0;     // [31:0] start_time, [63:32] end_time
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;           // [0] accepted, [2:1] status, [7:3] zero

    t_interval interval_requests[$];    // beats still to be offered
    t_interval offered[$];              // every interval generated so far
    t_verdict  pending_verdicts[$];     // verdicts still owed by the block
    t_verdict  due_verdict;
    t_verdict  fresh_verdict;
    t_interval next_req;

    // Shadow copy of the booking table.
    int booked_open[SLOTS];
    int booked_close[SLOTS];
    int booked_count = 0;

    int n_booked  = 0;
    int n_overlap = 0;
    int n_full    = 0;
    int n_results = 0;
    int n_errors  = 0;

    int   phase         = 0;
    int   send_idle_pct = 7;
    int   recv_idle_pct = 50;
    int   hold_left     = 0;
    logic held_off      = 1'b0;
    int   quiet_cycles  = 0;

    interval_booking_table_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decide one request against the shadow table and book it if it fits.
    // Overlap wins over a full table; reversed intervals are taken as given.
    function automatic t_verdict predict_booking(int open_at, int close_at);
        t_verdict v;
        logic     clash;
        clash = 1'b0;
        for (int i = 0; i < booked_count; i++) begin
            if ((open_at >= booked_open[i] && open_at <= booked_close[i]) ||
                (close_at >= booked_open[i] && close_at <= booked_close[i]) ||
                (open_at <= booked_open[i] && close_at >= booked_close[i]))
                clash = 1'b1;
        end
        if (clash) begin
            v.accepted = 1'b0;
            v.status   = STATUS_OVERLAP;
            n_overlap++;
        end else if (booked_count >= SLOTS) begin
            v.accepted = 1'b0;
            v.status   = STATUS_FULL;
            n_full++;
        end else begin
            booked_open[booked_count]  = open_at;
            booked_close[booked_count] = close_at;
            booked_count++;
            v.accepted = 1'b1;
            v.status   = STATUS_ACCEPTED;
            n_booked++;
        end
        return v;
    endfunction

    // Request driver: predict on every accepted beat, then offer the next one
    // or let valid fall idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                fresh_verdict    = predict_booking($signed(s_tdata[31:0]),
                                                   $signed(s_tdata[63:32]));
                pending_verdicts = {pending_verdicts, fresh_verdict};
            end
            if (!s_tvalid || s_tready) begin
                if (interval_requests.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = interval_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_req.close_at, next_req.open_at};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat against the oldest verdict, and hold
    // ready low for one long stretch at the start of the last phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (pending_verdicts.size() == 0) begin
                    $error("result beat with no request waiting: tdata %h", m_tdata);
                    n_errors++;
                end else begin
                    due_verdict = pending_verdicts.pop_front();
                    if (m_tdata[0] !== due_verdict.accepted) begin
                        $error("accepted mismatch: expected %0d, actual %0d",
                               due_verdict.accepted, m_tdata[0]);
                        n_errors++;
                    end
                    if (m_tdata[2:1] !== due_verdict.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               due_verdict.status, m_tdata[2:1]);
                        n_errors++;
                    end
                    if (m_tdata[7:3] !== 5'd0) begin
                        $error("pad mismatch: expected 0, actual %0d", m_tdata[7:3]);
                        n_errors++;
                    end
                end
            end
            if (phase == 2 && !held_off) begin
                held_off  = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_interval req;
        int        extremes[6];
        int        directed[14][2];
        int        made;
        int        pick;
        int        a;
        int        k;
        extremes = '{T_MIN, T_MAX, 0, -1, T_MIN + 1, T_MAX - 1};
        // Extremes, each way of overlapping, reversed intervals, a repeat.
        directed = '{'{T_MIN, T_MIN}, '{T_MAX, T_MAX}, '{T_MIN, T_MAX}, '{0, 10},
                     '{10, 20}, '{-5, 0}, '{11, 20}, '{2, 5}, '{-1, -1}, '{100, 50},
                     '{60, 90}, '{T_MIN + 1, T_MAX - 1}, '{25, 21}, '{11, 20}};
        made = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 14; i++) begin
            req = '{directed[i][0], directed[i][1]};
            interval_requests = {interval_requests, req};
            offered           = {offered, req};
        end

        for (int p = 0; p < 3; p++) begin
            phase         = p;
            send_idle_pct = (p == 0) ? 7 : (p == 1) ? 50 : 0;
            recv_idle_pct = (p == 0) ? 50 : (p == 1) ? 7 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Keep early requests narrow and ordered so the table fills;
                // wide and reversed ones would block most of the range.
                pick = (made < FILL_ITEMS) ? $urandom_range(0, 64) : $urandom_range(0, 99);
                k    = $urandom_range(0, 300);
                a    = $urandom_range(0, 400000);
                a    = a - 200000;
                if (pick < 45) begin
                    req = '{a, a + $urandom_range(0, 1000)};
                end else if (pick < 65) begin
                    // Land on or just past the edges of an earlier interval.
                    req = offered[$urandom_range(0, offered.size() - 1)];
                    case ($urandom_range(0, 5))
                        0: req = '{req.close_at, req.close_at + k};
                        1: req = '{req.open_at - k, req.open_at};
                        2: req = '{req.close_at + 1, req.close_at + 1 + k};
                        3: req = '{req.open_at - 1 - k, req.open_at - 1};
                        4: req = '{req.open_at - k, req.close_at + k};
                        default: ;
                    endcase
                end else if (pick < 80) begin
                    req = '{int'($urandom), int'($urandom)};
                end else if (pick < 90) begin
                    req = '{a + k, a};
                end else begin
                    req = '{extremes[$urandom_range(0, 5)], extremes[$urandom_range(0, 5)]};
                    if ($urandom_range(0, 1) == 1)
                        req.close_at = int'($urandom);
                end
                interval_requests = {interval_requests, req};
                offered           = {offered, req};
                made++;
            end
            while (interval_requests.size() != 0 || s_tvalid)
                @(posedge i_clk);
        end

        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests checked: %0d booked, %0d overlaps, %0d refused on a full table",
                 n_results, n_booked, n_overlap, n_full);
        $display("idle mixes: sender-light, receiver-light, none; one %0d-cycle result hold-off",
                 HOLD_OFF_CYCLES);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
